FILE: design/rcd_pkg.sv
// Shared types and constants for the grid raycaster column core.
`timescale 1ns / 1ps
package rcd_pkg;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV_CX, S_CX, S_RAY_X, S_RAY_Y, S_DIV_DX, S_DIV_DY,
    S_SIDE_X, S_SIDE_Y, S_STEP, S_CHECK, S_PERP, S_DIV_LH, S_DRAW
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_CX, OP_RAY_X, OP_RAY_Y, OP_DX, OP_DY,
    OP_SIDE_X, OP_SIDE_Y, OP_STEP, OP_PERP, OP_LH, OP_DRAW
  } op_t;

  typedef struct packed {
    op_t  op;
    logic map_wr;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic wall;
  } stat_t;

  localparam logic KIND_MAP  = 1'b0;
  localparam logic KIND_CAST = 1'b1;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 16;

  localparam logic [CFG_AW-1:0] REG_CAM_POS_X   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_CAM_POS_Y   = 3'd1;
  localparam logic [CFG_AW-1:0] REG_VIEW_DIR_X  = 3'd2;
  localparam logic [CFG_AW-1:0] REG_VIEW_DIR_Y  = 3'd3;
  localparam logic [CFG_AW-1:0] REG_PLANE_X     = 3'd4;
  localparam logic [CFG_AW-1:0] REG_PLANE_Y     = 3'd5;
  localparam logic [CFG_AW-1:0] REG_SCREEN_W    = 3'd6;
  localparam logic [CFG_AW-1:0] REG_SCREEN_H    = 3'd7;

  localparam int DIV_N   = 31;  // quotient bits per division
  localparam int DEN_W   = 48;
  localparam int DELTA_W = 41;
  localparam int SIDE_W  = 48;

  localparam logic signed [25:0]  CX_BIAS   = 26'sd16384;
  localparam logic [DIV_N-1:0]    DIV_ONE   = 31'h4000_0000;
  localparam logic [DELTA_W-1:0]  DELTA_SAT = 41'h100_0000_0000;
  localparam logic [15:0]         SAT16     = 16'hFFFF;

endpackage

FILE: design/rcd_ctrl.sv
// Sequencer for the raycaster: accepts items and steps the datapath.
`timescale 1ns / 1ps
module rcd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          in_kind,
  input  rcd_pkg::stat_t stat,
  output rcd_pkg::cmd_t cmd,
  output logic          busy
);

  rcd_pkg::state_t state_r, state_nxt;
  logic accept;

  assign busy   = (state_r != rcd_pkg::S_IDLE);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rcd_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rcd_pkg::S_IDLE: begin
        if (accept && (in_kind == rcd_pkg::KIND_CAST)) state_nxt = rcd_pkg::S_DIV_CX;
      end
      rcd_pkg::S_DIV_CX: begin
        if (stat.div_done) state_nxt = rcd_pkg::S_CX;
      end
      rcd_pkg::S_CX:     state_nxt = rcd_pkg::S_RAY_X;
      rcd_pkg::S_RAY_X:  state_nxt = rcd_pkg::S_RAY_Y;
      rcd_pkg::S_RAY_Y:  state_nxt = rcd_pkg::S_DIV_DX;
      rcd_pkg::S_DIV_DX: begin
        if (stat.div_done) state_nxt = rcd_pkg::S_DIV_DY;
      end
      rcd_pkg::S_DIV_DY: begin
        if (stat.div_done) state_nxt = rcd_pkg::S_SIDE_X;
      end
      rcd_pkg::S_SIDE_X: state_nxt = rcd_pkg::S_SIDE_Y;
      rcd_pkg::S_SIDE_Y: state_nxt = rcd_pkg::S_STEP;
      rcd_pkg::S_STEP:   state_nxt = rcd_pkg::S_CHECK;
      rcd_pkg::S_CHECK: begin
        state_nxt = stat.wall ? rcd_pkg::S_PERP : rcd_pkg::S_STEP;
      end
      rcd_pkg::S_PERP:   state_nxt = rcd_pkg::S_DIV_LH;
      rcd_pkg::S_DIV_LH: begin
        if (stat.div_done) state_nxt = rcd_pkg::S_DRAW;
      end
      rcd_pkg::S_DRAW:   state_nxt = rcd_pkg::S_IDLE;
      default:           state_nxt = rcd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op     = rcd_pkg::OP_NONE;
    cmd.map_wr = 1'b0;
    case (state_r)
      rcd_pkg::S_IDLE: begin
        if (accept && (in_kind == rcd_pkg::KIND_CAST)) cmd.op = rcd_pkg::OP_LOAD;
        cmd.map_wr = accept && (in_kind == rcd_pkg::KIND_MAP);
      end
      rcd_pkg::S_CX:     cmd.op = rcd_pkg::OP_CX;
      rcd_pkg::S_RAY_X:  cmd.op = rcd_pkg::OP_RAY_X;
      rcd_pkg::S_RAY_Y:  cmd.op = rcd_pkg::OP_RAY_Y;
      rcd_pkg::S_DIV_DX: begin
        if (stat.div_done) cmd.op = rcd_pkg::OP_DX;
      end
      rcd_pkg::S_DIV_DY: begin
        if (stat.div_done) cmd.op = rcd_pkg::OP_DY;
      end
      rcd_pkg::S_SIDE_X: cmd.op = rcd_pkg::OP_SIDE_X;
      rcd_pkg::S_SIDE_Y: cmd.op = rcd_pkg::OP_SIDE_Y;
      rcd_pkg::S_STEP:   cmd.op = rcd_pkg::OP_STEP;
      rcd_pkg::S_PERP:   cmd.op = rcd_pkg::OP_PERP;
      rcd_pkg::S_DIV_LH: begin
        if (stat.div_done) cmd.op = rcd_pkg::OP_LH;
      end
      rcd_pkg::S_DRAW:   cmd.op = rcd_pkg::OP_DRAW;
      default:           cmd.op = rcd_pkg::OP_NONE;
    endcase
  end

endmodule

FILE: design/rcd_dpath.sv
// Raycaster datapath: config registers, map store, divider, ray and DDA math.
`timescale 1ns / 1ps
module rcd_dpath #(
  parameter int MAP_SIZE = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rcd_pkg::cmd_t              cmd,
  output rcd_pkg::stat_t             stat,
  input  logic                       cfg_we,
  input  logic [rcd_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [rcd_pkg::CFG_DW-1:0] cfg_wdata,
  input  logic [3:0]                 in_map_row,
  input  logic [15:0]                in_row_bits,
  input  logic [9:0]                 in_column,
  output logic                       out_valid,
  output logic                       out_hit_side,
  output logic signed [5:0]          out_hit_x,
  output logic signed [5:0]          out_hit_y,
  output logic [15:0]                out_perp_dist,
  output logic [15:0]                out_wall_len,
  output logic [9:0]                 out_span_top,
  output logic [9:0]                 out_span_bot
);

  localparam int AW = (MAP_SIZE > 1) ? $clog2(MAP_SIZE) : 1;
  localparam int CW = (AW > 4) ? AW : 4;
  localparam int MW = CW + 2;

  // configuration
  logic [11:0]        cam_x_r, cam_y_r;
  logic signed [15:0] dir_x_r, dir_y_r, plane_x_r, plane_y_r;
  logic [10:0]        width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r   <= 12'd384;
      cam_y_r   <= 12'd384;
      dir_x_r   <= -16'sd16384;
      dir_y_r   <= 16'sd0;
      plane_x_r <= 16'sd0;
      plane_y_r <= 16'sd10813;
      width_r   <= 11'd640;
      height_r  <= 11'd480;
    end else if (cfg_we) begin
      case (cfg_addr)
        rcd_pkg::REG_CAM_POS_X:  cam_x_r   <= cfg_wdata[11:0];
        rcd_pkg::REG_CAM_POS_Y:  cam_y_r   <= cfg_wdata[11:0];
        rcd_pkg::REG_VIEW_DIR_X: dir_x_r   <= $signed(cfg_wdata);
        rcd_pkg::REG_VIEW_DIR_Y: dir_y_r   <= $signed(cfg_wdata);
        rcd_pkg::REG_PLANE_X:    plane_x_r <= $signed(cfg_wdata);
        rcd_pkg::REG_PLANE_Y:    plane_y_r <= $signed(cfg_wdata);
        rcd_pkg::REG_SCREEN_W:   width_r   <= cfg_wdata[10:0];
        rcd_pkg::REG_SCREEN_H:   height_r  <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  // working registers
  logic signed [25:0]         cx_r;
  logic signed [28:0]         rx_r, ry_r;
  logic [rcd_pkg::DELTA_W-1:0] dx_r, dy_r;
  logic [rcd_pkg::SIDE_W-1:0] sx_r, sy_r, perp_r;
  logic signed [MW-1:0]       mx_r, my_r;
  logic                       side_r;
  logic [15:0]                lh_r;

  // shared restoring divider, one quotient bit per cycle
  logic [rcd_pkg::DIV_N-1:0] div_num_r, div_q_r, div_num_in;
  logic [rcd_pkg::DEN_W-1:0] div_den_r, div_rem_r, div_den_in;
  logic [4:0]                div_cnt_r;
  logic                      div_act_r, div_done_r, div_start;
  logic [rcd_pkg::DEN_W:0]   div_trial, div_diff;
  logic                      div_ge;

  logic [27:0]                magx, magy;
  logic [rcd_pkg::SIDE_W-1:0] perp_nxt;

  assign magx = rx_r[28] ? 28'(-rx_r) : rx_r[27:0];
  assign magy = ry_r[28] ? 28'(-ry_r) : ry_r[27:0];
  assign perp_nxt = side_r ? (sy_r - rcd_pkg::SIDE_W'(dy_r))
                           : (sx_r - rcd_pkg::SIDE_W'(dx_r));

  assign div_start = cmd.op inside {rcd_pkg::OP_LOAD, rcd_pkg::OP_RAY_Y,
                                    rcd_pkg::OP_DX, rcd_pkg::OP_PERP};

  always_comb begin
    div_num_in = rcd_pkg::DIV_ONE;
    div_den_in = rcd_pkg::DEN_W'(1);
    case (cmd.op)
      rcd_pkg::OP_LOAD: begin
        div_num_in = rcd_pkg::DIV_N'({in_column, 15'b0});
        div_den_in = (width_r == 11'd0) ? rcd_pkg::DEN_W'(1) : rcd_pkg::DEN_W'(width_r);
      end
      rcd_pkg::OP_RAY_Y: begin
        div_den_in = (magx == 28'd0) ? rcd_pkg::DEN_W'(1) : rcd_pkg::DEN_W'(magx);
      end
      rcd_pkg::OP_DX: begin
        div_den_in = (magy == 28'd0) ? rcd_pkg::DEN_W'(1) : rcd_pkg::DEN_W'(magy);
      end
      rcd_pkg::OP_PERP: begin
        div_num_in = rcd_pkg::DIV_N'({height_r, 16'b0});
        div_den_in = (perp_nxt == '0) ? rcd_pkg::DEN_W'(1) : perp_nxt;
      end
      default: ;
    endcase
  end

  assign div_trial = {div_rem_r, div_num_r[rcd_pkg::DIV_N-1]};
  assign div_ge    = div_trial >= {1'b0, div_den_r};
  assign div_diff  = div_trial - {1'b0, div_den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_act_r  <= 1'b0;
      div_done_r <= 1'b0;
      div_cnt_r  <= '0;
    end else begin
      div_done_r <= !div_start && div_act_r
                 && (div_cnt_r == 5'(rcd_pkg::DIV_N - 1));
      if (div_start) begin
        div_act_r <= 1'b1;
        div_cnt_r <= '0;
      end else if (div_act_r) begin
        div_cnt_r <= div_cnt_r + 5'd1;
        if (div_cnt_r == 5'(rcd_pkg::DIV_N - 1)) begin
          div_act_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      div_num_r <= div_num_in;
      div_den_r <= div_den_in;
      div_rem_r <= '0;
      div_q_r   <= '0;
    end else if (div_act_r) begin
      div_rem_r <= div_ge ? div_diff[rcd_pkg::DEN_W-1:0] : div_trial[rcd_pkg::DEN_W-1:0];
      div_num_r <= {div_num_r[rcd_pkg::DIV_N-2:0], 1'b0};
      div_q_r   <= {div_q_r[rcd_pkg::DIV_N-2:0], div_ge};
    end
  end

  // shared ray multiplier
  logic signed [15:0] mul_a, dir_sel;
  logic signed [41:0] pmul;
  logic signed [28:0] ray_sum;

  assign mul_a   = (cmd.op == rcd_pkg::OP_RAY_Y) ? plane_y_r : plane_x_r;
  assign dir_sel = (cmd.op == rcd_pkg::OP_RAY_Y) ? dir_y_r : dir_x_r;
  assign pmul    = 42'(mul_a) * 42'(cx_r);
  assign ray_sum = 29'(dir_sel) + 29'(pmul >>> 14);

  // shared side-distance multiplier
  logic [8:0]                  fx, fy, f_sel;
  logic [rcd_pkg::DELTA_W-1:0] d_sel;
  logic [49:0]                 fmul;

  assign fx    = rx_r[28] ? {1'b0, cam_x_r[7:0]} : (9'd256 - {1'b0, cam_x_r[7:0]});
  assign fy    = ry_r[28] ? {1'b0, cam_y_r[7:0]} : (9'd256 - {1'b0, cam_y_r[7:0]});
  assign f_sel = (cmd.op == rcd_pkg::OP_SIDE_Y) ? fy : fx;
  assign d_sel = (cmd.op == rcd_pkg::OP_SIDE_Y) ? dy_r : dx_r;
  assign fmul  = 50'(f_sel) * 50'(d_sel);

  // DDA step
  logic                 x_first;
  logic signed [MW-1:0] mx_step, my_step;
  logic [AW-1:0]        rd_addr;

  assign x_first = sx_r < sy_r;
  assign mx_step = rx_r[28] ? (mx_r - MW'(1)) : (mx_r + MW'(1));
  assign my_step = ry_r[28] ? (my_r - MW'(1)) : (my_r + MW'(1));
  assign rd_addr = (cmd.op == rcd_pkg::OP_STEP && !x_first) ? AW'(my_step) : AW'(my_r);

  // map store
  logic [MAP_SIZE-1:0] map_mem [MAP_SIZE];
  logic [MAP_SIZE-1:0] row_vld_r;
  logic [MAP_SIZE-1:0] rd_row_r;
  logic                rd_vld_r;
  logic                row_ok;

  assign row_ok = 32'(in_map_row) < MAP_SIZE;

  always_ff @(posedge clk) begin
    if (cmd.map_wr && row_ok) begin
      map_mem[AW'(in_map_row)] <= MAP_SIZE'(in_row_bits);
    end
    rd_row_r <= map_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (cmd.map_wr && row_ok) row_vld_r[AW'(in_map_row)] <= 1'b1;
      rd_vld_r <= row_vld_r[rd_addr];
    end
  end

  logic oob;
  assign oob = mx_r[MW-1] || my_r[MW-1]
            || (mx_r[MW-2:0] >= (MW-1)'(MAP_SIZE))
            || (my_r[MW-2:0] >= (MW-1)'(MAP_SIZE));

  assign stat.wall     = oob || (rd_vld_r && rd_row_r[mx_r[AW-1:0]]);
  assign stat.div_done = div_done_r;

  // ray working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      rcd_pkg::OP_CX:     cx_r <= $signed({1'b0, div_q_r[24:0]}) - rcd_pkg::CX_BIAS;
      rcd_pkg::OP_RAY_X:  rx_r <= ray_sum;
      rcd_pkg::OP_RAY_Y:  ry_r <= ray_sum;
      rcd_pkg::OP_DX:     dx_r <= (magx == 28'd0) ? rcd_pkg::DELTA_SAT
                                                  : rcd_pkg::DELTA_W'(div_q_r);
      rcd_pkg::OP_DY:     dy_r <= (magy == 28'd0) ? rcd_pkg::DELTA_SAT
                                                  : rcd_pkg::DELTA_W'(div_q_r);
      rcd_pkg::OP_SIDE_X: sx_r <= rcd_pkg::SIDE_W'(fmul >> 8);
      rcd_pkg::OP_SIDE_Y: begin
        sy_r <= rcd_pkg::SIDE_W'(fmul >> 8);
        mx_r <= MW'(cam_x_r[11:8]);
        my_r <= MW'(cam_y_r[11:8]);
      end
      rcd_pkg::OP_STEP: begin
        if (x_first) begin
          sx_r   <= sx_r + rcd_pkg::SIDE_W'(dx_r);
          mx_r   <= mx_step;
          side_r <= 1'b0;
        end else begin
          sy_r   <= sy_r + rcd_pkg::SIDE_W'(dy_r);
          my_r   <= my_step;
          side_r <= 1'b1;
        end
      end
      rcd_pkg::OP_PERP:   perp_r <= perp_nxt;
      rcd_pkg::OP_LH: begin
        if (perp_r == '0 || div_q_r[rcd_pkg::DIV_N-1:16] != '0) lh_r <= rcd_pkg::SAT16;
        else lh_r <= div_q_r[15:0];
      end
      default: ;
    endcase
  end

  // wall span
  logic [9:0]  half;
  logic [14:0] lhh;
  logic [15:0] de_sum, de_v;
  logic [9:0]  ds_v;

  assign half = height_r[10:1];
  assign lhh  = lh_r[15:1];

  always_comb begin
    ds_v   = (15'(half) > lhh) ? 10'(15'(half) - lhh) : 10'd0;
    de_sum = 16'(lhh) + 16'(half);
    if (de_sum >= 16'(height_r)) begin
      de_v = (height_r == 11'd0) ? 16'd0 : 16'(height_r - 11'd1);
    end else begin
      de_v = de_sum;
    end
    if (de_v > 16'd1023) de_v = 16'd1023;
  end

  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.op == rcd_pkg::OP_DRAW);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == rcd_pkg::OP_DRAW) begin
      out_hit_side  <= side_r;
      out_hit_x     <= 6'(mx_r);
      out_hit_y     <= 6'(my_r);
      out_perp_dist <= (perp_r[rcd_pkg::SIDE_W-1:24] != '0) ? rcd_pkg::SAT16 : perp_r[23:8];
      out_wall_len  <= lh_r;
      out_span_top  <= ds_v;
      out_span_bot  <= de_v[9:0];
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: design/raycast_dda_column_core.sv
// Top level of the grid raycaster column core.
`timescale 1ns / 1ps
// Usage:
//  Input: drive start with in_kind and its fields; a beat is taken when
//  start is high and busy is low. in_kind 0 writes one map row (in_map_row,
//  in_row_bits) in that cycle and produces no result. in_kind 1 casts the
//  ray for in_column and produces exactly one result beat.
//  Output: out_valid is high for one cycle with the hit cell, side, the
//  perpendicular distance and the wall span. The receiver cannot stall.
//  Config: cfg_we writes cfg_wdata into register cfg_addr; write only while
//  busy is low and no cast is pending.
//  Sequence: a cast holds busy high through four divisions on one
//  shared radix-2 divider, seven states that do not wait and, per grid
//  step, a read of the map row, then the wall test. The result beat is in
//  the first cycle with busy low again, and the next beat may be taken in
//  that same cycle. One cast is in flight at a time.
//  Reset: configuration returns to its defaults and the map reads as empty.
module raycast_dda_column_core #(
  parameter int MAP_SIZE = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_kind,
  input  logic [3:0]                 in_map_row,
  input  logic [15:0]                in_row_bits,
  input  logic [9:0]                 in_column,
  output logic                       out_valid,
  output logic                       out_hit_side,
  output logic signed [5:0]          out_hit_x,
  output logic signed [5:0]          out_hit_y,
  output logic [15:0]                out_perp_dist,
  output logic [15:0]                out_wall_len,
  output logic [9:0]                 out_span_top,
  output logic [9:0]                 out_span_bot,
  input  logic                       cfg_we,
  input  logic [rcd_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [rcd_pkg::CFG_DW-1:0] cfg_wdata
);

  rcd_pkg::cmd_t  cmd;
  rcd_pkg::stat_t stat;

  rcd_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_kind),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  rcd_dpath #(.MAP_SIZE(MAP_SIZE)) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_map_row    (in_map_row),
    .in_row_bits   (in_row_bits),
    .in_column     (in_column),
    .out_valid     (out_valid),
    .out_hit_side  (out_hit_side),
    .out_hit_x     (out_hit_x),
    .out_hit_y     (out_hit_y),
    .out_perp_dist (out_perp_dist),
    .out_wall_len  (out_wall_len),
    .out_span_top  (out_span_top),
    .out_span_bot  (out_span_bot)
  );

  a_cast_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_kind == rcd_pkg::KIND_CAST) |=> busy)
    else $error("cast beat did not start a cast");

  a_map_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_kind == rcd_pkg::KIND_MAP) |=> (!busy && !out_valid))
    else $error("map row beat caused activity");

  a_result_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && !$past(out_valid)))
    else $error("result beat outside end of cast");

endmodule

FILE: dv/raycast_dda_column_core_test.sv
// Testbench for the grid raycaster column core: map writes, casts and settings.
`timescale 1ns / 1ps
module raycast_dda_column_core_test;

  typedef struct packed {
    logic        side;
    logic [5:0]  hx;
    logic [5:0]  hy;
    logic [15:0] pd;
    logic [15:0] lh;
    logic [9:0]  ds;
    logic [9:0]  de;
  } cast_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_kind = rcd_pkg::KIND_MAP;
  logic [3:0] in_map_row = '0;
  logic [15:0] in_row_bits = '0;
  logic [9:0] in_column = '0;
  logic out_valid, out_hit_side;
  logic signed [5:0] out_hit_x, out_hit_y;
  logic [15:0] out_perp_dist, out_wall_len;
  logic [9:0] out_span_top, out_span_bot;
  logic cfg_we = 1'b0;
  logic [rcd_pkg::CFG_AW-1:0] cfg_addr = '0;
  logic [rcd_pkg::CFG_DW-1:0] cfg_wdata = '0;

  logic [11:0] m_pos_x, m_pos_y;
  logic [15:0] m_dir_x, m_dir_y, m_plane_x, m_plane_y;
  logic [10:0] m_width, m_height;
  logic [15:0] m_map [16];

  cast_res_t hits_pending[$];
  int errors = 0;
  int casts_sent = 0;
  int rows_sent = 0;
  int results_seen = 0;
  bit quiet = 1'b0;

  raycast_dda_column_core i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_map_row(in_map_row), .in_row_bits(in_row_bits),
    .in_column(in_column), .out_valid(out_valid), .out_hit_side(out_hit_side),
    .out_hit_x(out_hit_x), .out_hit_y(out_hit_y), .out_perp_dist(out_perp_dist),
    .out_wall_len(out_wall_len), .out_span_top(out_span_top),
    .out_span_bot(out_span_bot), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  task automatic report(string what, longint got, longint exp);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
  endtask

  task automatic axis_setup(input longint r, input logic [11:0] pos,
                            output longint delta, output longint sd,
                            output longint stp);
    longint mag, frac;
    mag = (r < 0) ? -r : r;
    frac = pos[7:0];
    delta = (mag == 0) ? (64'sd1 <<< 40) : ((64'sd1 <<< 30) / mag);
    if (r < 0) begin
      stp = -1;
      sd = (frac * delta) >>> 8;
    end else begin
      stp = 1;
      sd = ((256 - frac) * delta) >>> 8;
    end
  endtask

  function automatic bit cell_is_wall(longint x, longint y);
    if (x < 0 || y < 0 || x >= 16 || y >= 16) return 1'b1;
    return m_map[y][x];
  endfunction

  task automatic predict_cast(input logic [9:0] col, output cast_res_t r);
    longint w, h, cx, rx, ry, dx, dy, sx, sy, stx, sty, mx, my;
    longint perp, lh, pd, half, ds, de;
    int guard;
    logic side;
    side = 1'b0;
    guard = 0;
    w = (m_width != 0) ? longint'(m_width) : 1;
    h = m_height;
    cx = ((longint'(col) * 2) <<< 14) / w - 16384;
    rx = longint'($signed(m_dir_x)) + ((longint'($signed(m_plane_x)) * cx) >>> 14);
    ry = longint'($signed(m_dir_y)) + ((longint'($signed(m_plane_y)) * cx) >>> 14);
    axis_setup(rx, m_pos_x, dx, sx, stx);
    axis_setup(ry, m_pos_y, dy, sy, sty);
    mx = m_pos_x[11:8];
    my = m_pos_y[11:8];
    do begin
      if (sx < sy) begin
        sx += dx;
        mx += stx;
        side = 1'b0;
      end else begin
        sy += dy;
        my += sty;
        side = 1'b1;
      end
      guard++;
    end while (!cell_is_wall(mx, my) && guard < 1000);
    perp = side ? sy - dy : sx - dx;
    pd = perp >>> 8;
    if (pd > 65535) pd = 65535;
    if (perp == 0) lh = 65535;
    else begin
      lh = (h <<< 16) / perp;
      if (lh > 65535) lh = 65535;
    end
    half = h / 2;
    ds = half - lh / 2;
    if (ds < 0) ds = 0;
    de = lh / 2 + half;
    if (de >= h) de = h - 1;
    if (de < 0) de = 0;
    if (de > 1023) de = 1023;
    r.side = side;
    r.hx = mx[5:0];
    r.hy = my[5:0];
    r.pd = pd[15:0];
    r.lh = lh[15:0];
    r.ds = ds[9:0];
    r.de = de[9:0];
  endtask

  always @(posedge clk) begin
    cast_res_t e;
    if (rst_n && out_valid) begin
      results_seen++;
      if (hits_pending.size() == 0) report("unexpected result", 1, 0);
      else begin
        e = hits_pending.pop_front();
        if (out_hit_side !== e.side) report("hit_side", out_hit_side, e.side);
        if (out_hit_x !== e.hx) report("hit_x", out_hit_x, $signed(e.hx));
        if (out_hit_y !== e.hy) report("hit_y", out_hit_y, $signed(e.hy));
        if (out_perp_dist !== e.pd) report("perp_dist", out_perp_dist, e.pd);
        if (out_wall_len !== e.lh) report("wall_len", out_wall_len, e.lh);
        if (out_span_top !== e.ds) report("span_top", out_span_top, e.ds);
        if (out_span_bot !== e.de) report("span_bot", out_span_bot, e.de);
      end
    end
  end

  // one beat: hold start until busy is low at a rising edge
  task automatic send_item(logic kind, logic [3:0] row, logic [15:0] bits,
                           logic [9:0] col);
    cast_res_t r;
    if (!quiet && $urandom_range(2) == 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(11)) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_kind <= kind;
    in_map_row <= row;
    in_row_bits <= bits;
    in_column <= col;
    do @(posedge clk); while (busy);
    if (kind == rcd_pkg::KIND_MAP) begin
      m_map[row] = bits;
      rows_sent++;
    end else begin
      predict_cast(col, r);
      hits_pending.push_back(r);
      casts_sent++;
    end
  endtask

  task automatic settle();
    int n;
    n = 0;
    @(negedge clk);
    start <= 1'b0;
    while (hits_pending.size() != 0 && n < 100000) begin
      @(posedge clk);
      n++;
    end
    repeat (300) @(posedge clk);
  endtask

  task automatic cfg_write(logic [rcd_pkg::CFG_AW-1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      rcd_pkg::REG_CAM_POS_X:  m_pos_x = val[11:0];
      rcd_pkg::REG_CAM_POS_Y:  m_pos_y = val[11:0];
      rcd_pkg::REG_VIEW_DIR_X: m_dir_x = val;
      rcd_pkg::REG_VIEW_DIR_Y: m_dir_y = val;
      rcd_pkg::REG_PLANE_X:    m_plane_x = val;
      rcd_pkg::REG_PLANE_Y:    m_plane_y = val;
      rcd_pkg::REG_SCREEN_W:   m_width = val[10:0];
      default:                 m_height = val[10:0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_camera(logic [11:0] px, logic [11:0] py, logic [15:0] dx,
                            logic [15:0] dy, logic [15:0] plx, logic [15:0] ply,
                            logic [10:0] w, logic [10:0] h);
    settle();
    cfg_write(rcd_pkg::REG_CAM_POS_X, 16'(px));
    cfg_write(rcd_pkg::REG_CAM_POS_Y, 16'(py));
    cfg_write(rcd_pkg::REG_VIEW_DIR_X, dx);
    cfg_write(rcd_pkg::REG_VIEW_DIR_Y, dy);
    cfg_write(rcd_pkg::REG_PLANE_X, plx);
    cfg_write(rcd_pkg::REG_PLANE_Y, ply);
    cfg_write(rcd_pkg::REG_SCREEN_W, 16'(w));
    cfg_write(rcd_pkg::REG_SCREEN_H, 16'(h));
  endtask

  task automatic test_reset_defaults();
    send_item(rcd_pkg::KIND_CAST, 4'd0, 16'd0, 10'd0);
    send_item(rcd_pkg::KIND_CAST, 4'd0, 16'd0, 10'd320);
    send_item(rcd_pkg::KIND_CAST, 4'd0, 16'd0, 10'd639);
  endtask

  task automatic test_map_rows();
    send_item(rcd_pkg::KIND_MAP, 4'd0, 16'hFFFF, 10'd0);
    send_item(rcd_pkg::KIND_MAP, 4'd15, 16'hFFFF, 10'd0);
    send_item(rcd_pkg::KIND_MAP, 4'd5, 16'h0001, 10'd0);
    send_item(rcd_pkg::KIND_MAP, 4'd5, 16'h8001, 10'd0);
    send_item(rcd_pkg::KIND_MAP, 4'd2, 16'h0000, 10'd0);
    send_item(rcd_pkg::KIND_CAST, 4'd0, 16'd0, 10'd100);
    send_item(rcd_pkg::KIND_CAST, 4'd0, 16'd0, 10'd1023);
  endtask

  task automatic test_config_extremes();
    // axis-aligned ray with a zero component
    set_camera(12'h180, 12'h180, 16'h4000, 16'h0000, 16'h0000, 16'h0000,
               11'd1, 11'd1024);
    send_item(rcd_pkg::KIND_CAST, 4'd0, 16'd0, 10'd0);
    send_item(rcd_pkg::KIND_CAST, 4'd0, 16'd0, 10'd1);
    set_camera(12'h000, 12'hFFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000,
               11'd1024, 11'd1);
    send_item(rcd_pkg::KIND_CAST, 4'd0, 16'd0, 10'd0);
    send_item(rcd_pkg::KIND_CAST, 4'd0, 16'd0, 10'd1023);
    send_item(rcd_pkg::KIND_CAST, 4'd0, 16'd0, 10'd512);
    set_camera(12'hFFF, 12'h000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF,
               11'd0, 11'd0);
    send_item(rcd_pkg::KIND_CAST, 4'd0, 16'd0, 10'd0);
    send_item(rcd_pkg::KIND_CAST, 4'd0, 16'd0, 10'd1023);
    set_camera(12'h100, 12'h100, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
               11'd7, 11'd1024);
    send_item(rcd_pkg::KIND_CAST, 4'd0, 16'd0, 10'd3);
    set_camera(12'h7FF, 12'h7FF, 16'h1000, 16'hF000, 16'h0800, 16'h2000,
               11'd3, 11'd2047);
    send_item(rcd_pkg::KIND_CAST, 4'd0, 16'd0, 10'd2);
    send_item(rcd_pkg::KIND_CAST, 4'd0, 16'd0, 10'd9);
  endtask

  task automatic test_random_scenes();
    int sent;
    logic [10:0] w;
    sent = 0;
    while (sent < 500) begin
      w = ($urandom_range(4) == 0) ? 11'($urandom_range(1024)) : 11'($urandom_range(1, 64));
      set_camera(12'($urandom), 12'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom), w, 11'($urandom_range(1, 1024)));
      for (int r = 0; r < 16; r++)
        if ($urandom_range(2) != 0) begin
          send_item(rcd_pkg::KIND_MAP, 4'(r), 16'($urandom) & 16'($urandom), 10'd0);
          sent++;
        end
      for (int k = 0; k < 40; k++) begin
        quiet = (sent > 400);
        if ($urandom_range(9) == 0)
          send_item(rcd_pkg::KIND_MAP, 4'($urandom), 16'($urandom), 10'd0);
        else if ($urandom_range(5) == 0)
          send_item(rcd_pkg::KIND_CAST, 4'd0, 16'd0, 10'($urandom));
        else
          send_item(rcd_pkg::KIND_CAST, 4'd0, 16'd0,
                    10'($urandom_range(w == 0 ? 0 : w - 1)));
        sent++;
      end
    end
  endtask

  initial begin
    m_pos_x = 12'd384;
    m_pos_y = 12'd384;
    m_dir_x = 16'hC000;
    m_dir_y = 16'h0000;
    m_plane_x = 16'h0000;
    m_plane_y = 16'd10813;
    m_width = 11'd640;
    m_height = 11'd480;
    foreach (m_map[i]) m_map[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_map_rows();
    test_config_extremes();
    test_random_scenes();
    settle();
    $display("covered %0d casts and %0d map row writes, %0d results checked",
             casts_sent, rows_sent, results_seen);
    if (hits_pending.size() != 0) report("results left over", hits_pending.size(), 0);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

FILE: sim.f
design/rcd_pkg.sv
design/rcd_ctrl.sv
design/rcd_dpath.sv
design/raycast_dda_column_core.sv
dv/raycast_dda_column_core_test.sv
